>>> rtl/ahd_pkg.sv
// Shared constants, widths and the arctangent table for the haversine distance pipeline.
package ahd_pkg;

    localparam int CORDIC_STAGES_DEF  = 32;
    localparam int DIST_FRAC_BITS_DEF = 8;

    // field widths
    localparam int LAT_W    = 31;
    localparam int LNG_W    = 32;
    localparam int RADIUS_W = 23;
    localparam int DIST_W   = 33;

    // internal widths
    localparam int MAG_W = 33;   // |degree difference|
    localparam int RAD_W = 30;   // degrees-to-radians factor
    localparam int Q_W   = 35;   // half angles in Q31
    localparam int P_W   = 36;   // cos * dLon in Q31
    localparam int CX_W  = 34;   // cosine CORDIC x/y
    localparam int AX_W  = 35;   // atan2 CORDIC x/y
    localparam int Z_W   = 34;   // CORDIC angle accumulators
    localparam int F_W   = 63;   // f in Q62
    localparam int ANG_W = 31;   // final angle in Q30

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_DIV = 64'd360 << 24;
    localparam logic [63:0] RAD_PER_UNIT_64 = (PI_Q60 + (DEG_DIV >> 1)) / DEG_DIV;
    localparam logic [RAD_W-1:0] RAD_PER_UNIT = RAD_PER_UNIT_64[RAD_W-1:0];
    localparam logic [63:0] PI_Q30_64      = (PI_Q60 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] HALF_PI_Q30_64 = (PI_Q60 + (64'd1 << 30)) >> 31;
    localparam logic [Q_W-1:0]   PI_Q30      = PI_Q30_64[Q_W-1:0];
    localparam logic [Q_W-1:0]   HALF_PI_Q30 = HALF_PI_Q30_64[Q_W-1:0];
    localparam logic [ANG_W-1:0] HALF_PI_ANG = HALF_PI_Q30_64[ANG_W-1:0];
    localparam logic [CX_W-1:0]  CORDIC_GAIN_Q30 = CX_W'(652032874);
    localparam logic [CX_W-1:0]  ONE_Q30  = CX_W'(64'd1 << 30);
    localparam logic [Q_W-1:0]   ONE_Q31  = Q_W'(64'd1 << 31);
    localparam logic [F_W-1:0]   ONE_Q62  = F_W'(64'd1 << 62);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6371000);
    localparam logic [DIST_W-1:0]   DIST_MAX = '1;

    // arctangent of 2^-i in Q30, truncated
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] r;
        case (i)
            0:  r = 30'd843314856;
            1:  r = 30'd497837829;
            2:  r = 30'd263043836;
            3:  r = 30'd133525158;
            4:  r = 30'd67021686;
            5:  r = 30'd33543515;
            6:  r = 30'd16775850;
            7:  r = 30'd8388437;
            8:  r = 30'd4194282;
            9:  r = 30'd2097149;
            10: r = 30'd1048575;
            default: r = (i <= 30) ? (30'd1 << (30 - i)) : 30'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/approx_haversine_distance.sv
// Top level: pipelined small-angle haversine distance between two fixed-point points.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | from_lat, from_lng, to_lat, to_lng
//  m_      | out       | m_valid / m_ready  | distance_q8, clamped
//  cfg_    | in        | cfg_we             | cfg_wdata = sphere radius in meters
//
// One transaction enters per cycle while s_ready is high; the pipeline holds
// two CORDIC chains of CORDIC_STAGES cells, 32 square-root cells, 10 other stages.
// The whole pipeline advances together: it moves when the output register is
// empty or being taken, so s_ready is low only while m_valid waits on m_ready.
// Synchronous active-low reset clears all valid bits and loads the default radius.
module approx_haversine_distance #(
    parameter int CORDIC_STAGES  = ahd_pkg::CORDIC_STAGES_DEF,
    parameter int DIST_FRAC_BITS = ahd_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ahd_pkg::RADIUS_W-1:0]     cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [ahd_pkg::LAT_W-1:0] s_from_lat,
    input  logic signed [ahd_pkg::LNG_W-1:0] s_from_lng,
    input  logic signed [ahd_pkg::LAT_W-1:0] s_to_lat,
    input  logic signed [ahd_pkg::LNG_W-1:0] s_to_lng,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ahd_pkg::DIST_W-1:0]       m_distance_q8,
    output logic                             m_clamped
);
    import ahd_pkg::*;

    localparam int SH     = 29 - DIST_FRAC_BITS;   // includes the factor two
    localparam int PROD_W = RADIUS_W + ANG_W;
    localparam int SB_CW  = 2 * Q_W;

    logic en;

    // ---------------- radius register ----------------
    logic [RADIUS_W-1:0] radius_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_we) begin
            radius_reg <= cfg_wdata;
        end
    end

    // ---------------- valid chain of the plain stages ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic m_valid_reg;
    logic cos_valid, sqrt_valid, atan_valid;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
            v7_reg <= 1'b0; v8_reg <= 1'b0; v9_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= cos_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= atan_valid;
            v9_reg <= v8_reg;
            m_valid_reg <= v9_reg;
        end
    end

    // ---------------- stage 1: magnitudes ----------------
    logic signed [MAG_W:0] lat0_s, dlat_s, dlng_s;
    logic [MAG_W-1:0] mlat0_next, mdlat_next, mdlng_next;
    logic [MAG_W-1:0] mlat0_reg, mdlat_reg, mdlng_reg;

    assign lat0_s = (MAG_W+1)'(s_from_lat);
    assign dlat_s = (MAG_W+1)'(s_to_lat) - (MAG_W+1)'(s_from_lat);
    assign dlng_s = (MAG_W+1)'(s_to_lng) - (MAG_W+1)'(s_from_lng);
    assign mlat0_next = MAG_W'(lat0_s[MAG_W] ? -lat0_s : lat0_s);
    assign mdlat_next = MAG_W'(dlat_s[MAG_W] ? -dlat_s : dlat_s);
    assign mdlng_next = MAG_W'(dlng_s[MAG_W] ? -dlng_s : dlng_s);

    always_ff @(posedge aclk) begin
        if (en) begin
            mlat0_reg <= mlat0_next;
            mdlat_reg <= mdlat_next;
            mdlng_reg <= mdlng_next;
        end
    end

    // ---------------- stage 2: degrees to half-angle radians (Q31) ----------------
    localparam int MP_W = MAG_W + RAD_W + 1;
    logic [MP_W-1:0] pth, pa, plon;
    logic [Q_W-1:0]  th_next, a_next, lon_next;
    logic [Q_W-1:0]  th_reg, a2_reg, lon2_reg;

    assign pth  = MP_W'(mlat0_reg) * MP_W'(RAD_PER_UNIT) + (MP_W'(1) << 27);
    assign pa   = MP_W'(mdlat_reg) * MP_W'(RAD_PER_UNIT) + (MP_W'(1) << 27);
    assign plon = MP_W'(mdlng_reg) * MP_W'(RAD_PER_UNIT) + (MP_W'(1) << 27);
    assign th_next  = Q_W'(pth  >> 28);
    assign a_next   = Q_W'(pa   >> 28);
    assign lon_next = Q_W'(plon >> 28);

    always_ff @(posedge aclk) begin
        if (en) begin
            th_reg   <= th_next;
            a2_reg   <= a_next;
            lon2_reg <= lon_next;
        end
    end

    // ---------------- stage 3: fold latitude past ninety degrees ----------------
    logic signed [Z_W-1:0] z0_next, z0_reg;
    logic [Q_W-1:0] a3_reg, lon3_reg;

    assign z0_next = (th_reg > HALF_PI_Q30) ? Z_W'(PI_Q30 - th_reg) : Z_W'(th_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg   <= z0_next;
            a3_reg   <= a2_reg;
            lon3_reg <= lon2_reg;
        end
    end

    // ---------------- cosine CORDIC chain (rotation mode) ----------------
    logic                   cv   [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] cx   [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] cy   [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  cz   [CORDIC_STAGES+1];
    logic [SB_CW-1:0]       csb  [CORDIC_STAGES+1];

    assign cv[0]  = v3_reg;
    assign cx[0]  = CORDIC_GAIN_Q30;
    assign cy[0]  = '0;
    assign cz[0]  = z0_reg;
    assign csb[0] = {a3_reg, lon3_reg};

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cos
        ahd_cordic_cell #(
            .STAGE (i),
            .VECTOR(1'b0),
            .XY_W  (CX_W),
            .ZW    (Z_W),
            .SB_W  (SB_CW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cv[i]),
            .x_in     (cx[i]),
            .y_in     (cy[i]),
            .z_in     (cz[i]),
            .sb_in    (csb[i]),
            .out_valid(cv[i+1]),
            .x_out    (cx[i+1]),
            .y_out    (cy[i+1]),
            .z_out    (cz[i+1]),
            .sb_out   (csb[i+1])
        );
    end
    assign cos_valid = cv[CORDIC_STAGES];

    // ---------------- stage 4: |cos| capped at one, widened to Q31 ----------------
    logic [CX_W-1:0] cabs;
    logic [31:0]     c31_next, c31_reg;
    logic [Q_W-1:0]  a4_reg, lon4_reg;

    assign cabs     = cx[CORDIC_STAGES][CX_W-1] ? CX_W'(-cx[CORDIC_STAGES])
                                                : CX_W'(cx[CORDIC_STAGES]);
    assign c31_next = (cabs > ONE_Q30) ? 32'h8000_0000 : {cabs[30:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            c31_reg  <= c31_next;
            a4_reg   <= csb[CORDIC_STAGES][SB_CW-1:Q_W];
            lon4_reg <= csb[CORDIC_STAGES][Q_W-1:0];
        end
    end

    // ---------------- stage 5: p = cos * dLon, rounded Q31 ----------------
    logic [Q_W-33:0] lon_hi;
    logic [31:0]     lon_lo;
    logic [P_W-1:0]  phi;
    logic [64:0]     plo;
    logic [P_W-1:0]  p_next, p_reg;
    logic [Q_W-1:0]  a5_reg;

    assign lon_hi = lon4_reg[Q_W-1:32];
    assign lon_lo = lon4_reg[31:0];
    assign phi    = P_W'(lon_hi) * P_W'(c31_reg);
    assign plo    = 65'(lon_lo) * 65'(c31_reg) + (65'd1 << 30);
    assign p_next = (phi << 1) + P_W'(plo >> 31);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg  <= p_next;
            a5_reg <= a4_reg;
        end
    end

    // ---------------- stage 6: squares ----------------
    logic        big_next, big_reg;
    logic [63:0] asq_next, psq_next, asq_reg, psq_reg;

    assign big_next = (a5_reg > ONE_Q31) || (p_reg > P_W'(ONE_Q31));
    assign asq_next = 64'(a5_reg[31:0]) * 64'(a5_reg[31:0]);
    assign psq_next = 64'(p_reg[31:0]) * 64'(p_reg[31:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg <= big_next;
            asq_reg <= asq_next;
            psq_reg <= psq_next;
        end
    end

    // ---------------- stage 7: f and 1 - f, clamp to one ----------------
    logic [64:0]    fsum;
    logic           clamp_next, clamp_reg;
    logic [F_W-1:0] f_next, f_reg, g_reg;

    assign fsum       = 65'(asq_reg) + 65'(psq_reg);
    assign clamp_next = big_reg || (fsum > 65'(ONE_Q62));
    assign f_next     = clamp_next ? ONE_Q62 : F_W'(fsum);

    always_ff @(posedge aclk) begin
        if (en) begin
            clamp_reg <= clamp_next;
            f_reg     <= f_next;
            g_reg     <= ONE_Q62 - f_next;
        end
    end

    // ---------------- square-root chain, two lanes ----------------
    localparam int SQ_STEPS = 32;
    logic           qv  [SQ_STEPS+1];
    logic [F_W-1:0] qvv [SQ_STEPS+1][2];
    logic [F_W-1:0] qr  [SQ_STEPS+1][2];
    logic           qsb [SQ_STEPS+1];

    assign qv[0]     = v7_reg;
    assign qvv[0][0] = f_reg;
    assign qvv[0][1] = g_reg;
    assign qr[0][0]  = '0;
    assign qr[0][1]  = '0;
    assign qsb[0]    = clamp_reg;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        ahd_isqrt_cell #(
            .STEP(k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (qv[k]),
            .v_in     (qvv[k]),
            .r_in     (qr[k]),
            .sb_in    (qsb[k]),
            .out_valid(qv[k+1]),
            .v_out    (qvv[k+1]),
            .r_out    (qr[k+1]),
            .sb_out   (qsb[k+1])
        );
    end
    assign sqrt_valid = qv[SQ_STEPS];

    // ---------------- atan2 CORDIC chain (vectoring mode) ----------------
    logic                   av  [CORDIC_STAGES+1];
    logic signed [AX_W-1:0] ax  [CORDIC_STAGES+1];
    logic signed [AX_W-1:0] ay  [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  az  [CORDIC_STAGES+1];
    logic                   asb [CORDIC_STAGES+1];

    // x = sqrt(1 - f), y = sqrt(f); both at most 2^31
    assign av[0]  = sqrt_valid;
    assign ax[0]  = AX_W'(qr[SQ_STEPS][1][31:0]);
    assign ay[0]  = AX_W'(qr[SQ_STEPS][0][31:0]);
    assign az[0]  = '0;
    assign asb[0] = qsb[SQ_STEPS];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_atan
        ahd_cordic_cell #(
            .STAGE (i),
            .VECTOR(1'b1),
            .XY_W  (AX_W),
            .ZW    (Z_W),
            .SB_W  (1)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (av[i]),
            .x_in     (ax[i]),
            .y_in     (ay[i]),
            .z_in     (az[i]),
            .sb_in    (asb[i]),
            .out_valid(av[i+1]),
            .x_out    (ax[i+1]),
            .y_out    (ay[i+1]),
            .z_out    (az[i+1]),
            .sb_out   (asb[i+1])
        );
    end
    assign atan_valid = av[CORDIC_STAGES];

    // ---------------- stage 8: clamp angle to [0, pi/2] ----------------
    logic signed [Z_W-1:0] zf;
    logic [ANG_W-1:0]      ang_next, ang_reg;
    logic                  clamp8_reg;

    assign zf = az[CORDIC_STAGES];
    always_comb begin
        if (zf[Z_W-1]) begin
            ang_next = '0;
        end else if (zf > Z_W'(HALF_PI_ANG)) begin
            ang_next = HALF_PI_ANG;
        end else begin
            ang_next = ANG_W'(zf);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg    <= ang_next;
            clamp8_reg <= asb[CORDIC_STAGES];
        end
    end

    // ---------------- stage 9: radius * angle ----------------
    logic [PROD_W-1:0] prod_next, prod_reg;
    logic              clamp9_reg;

    assign prod_next = PROD_W'(radius_reg) * PROD_W'(ang_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= prod_next;
            clamp9_reg <= clamp8_reg;
        end
    end

    // ---------------- stage 10: round, scale, saturate; output register ----------------
    logic [PROD_W:0]   rnd;
    logic [PROD_W:0]   dsh;
    logic [DIST_W-1:0] dist_next, dist_reg;
    logic              clamp_out_reg;

    assign rnd       = (PROD_W+1)'(prod_reg) + ((PROD_W+1)'(1) << (SH - 1));
    assign dsh       = rnd >> SH;
    assign dist_next = (dsh > (PROD_W+1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(dsh);

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg      <= dist_next;
            clamp_out_reg <= clamp9_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_distance_q8 = dist_reg;
    assign m_clamped     = clamp_out_reg;

endmodule

>>> rtl/ahd_cordic_cell.sv
// One CORDIC micro-rotation stage, rotation or vectoring mode, with a carried sideband.
module ahd_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0,
    parameter int XY_W   = 34,
    parameter int ZW     = 34,
    parameter int SB_W   = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [ZW-1:0]   z_in,
    input  logic [SB_W-1:0]        sb_in,
    output logic                   out_valid,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [ZW-1:0]   z_out,
    output logic [SB_W-1:0]        sb_out
);
    import ahd_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(STAGE));

    logic signed [XY_W-1:0] dx, dy;
    logic                   pos;
    logic signed [XY_W-1:0] x_next, y_next;
    logic signed [ZW-1:0]   z_next;
    logic                   valid_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [ZW-1:0]   z_reg;
    logic [SB_W-1:0]        sb_reg;

    assign dx  = y_in >>> STAGE;
    assign dy  = x_in >>> STAGE;
    assign pos = VECTOR ? !y_in[XY_W-1] : !z_in[ZW-1];

    always_comb begin
        if (VECTOR) begin
            x_next = pos ? x_in + dx : x_in - dx;
            y_next = pos ? y_in - dy : y_in + dy;
            z_next = pos ? z_in + ATAN : z_in - ATAN;
        end else begin
            x_next = pos ? x_in - dx : x_in + dx;
            y_next = pos ? y_in + dy : y_in - dy;
            z_next = pos ? z_in - ATAN : z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            sb_reg <= sb_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign sb_out    = sb_reg;

endmodule

>>> rtl/ahd_isqrt_cell.sv
// One bit-pair step of two parallel floor square roots.
module ahd_isqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ahd_pkg::F_W-1:0]     v_in [2],
    input  logic [ahd_pkg::F_W-1:0]     r_in [2],
    input  logic                        sb_in,
    output logic                        out_valid,
    output logic [ahd_pkg::F_W-1:0]     v_out [2],
    output logic [ahd_pkg::F_W-1:0]     r_out [2],
    output logic                        sb_out
);
    import ahd_pkg::*;

    localparam logic [F_W-1:0] BIT = F_W'(1) << (62 - 2 * STEP);

    logic [F_W-1:0] v_next [2];
    logic [F_W-1:0] r_next [2];
    logic [F_W-1:0] v_reg  [2];
    logic [F_W-1:0] r_reg  [2];
    logic           valid_reg;
    logic           sb_reg;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [F_W-1:0] trial;
        assign trial = r_in[l] + BIT;
        always_comb begin
            if (v_in[l] >= trial) begin
                v_next[l] = v_in[l] - trial;
                r_next[l] = (r_in[l] >> 1) + BIT;
            end else begin
                v_next[l] = v_in[l];
                r_next[l] = r_in[l] >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[l] <= v_next[l];
                r_reg[l] <= r_next[l];
            end
        end
        assign v_out[l] = v_reg[l];
        assign r_out[l] = r_reg[l];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg <= sb_in;
        end
    end

    assign out_valid = valid_reg;
    assign sb_out    = sb_reg;

endmodule

>>> rtl/ahd_checker.sv
// Port-level checker for the haversine distance block, bound to the top level.
module ahd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [ahd_pkg::DIST_W-1:0]   m_distance_q8,
    input logic                         m_clamped
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_q8) && $stable(m_clamped))
        else $error("stalled result changed");

    // a stalled output freezes the pipeline input
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // an empty output never blocks the input
    a_free_in: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // an offered input transaction stays offered until taken
    a_in_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("s_valid dropped before acceptance");

endmodule

bind approx_haversine_distance ahd_checker u_ahd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_distance_q8(m_distance_q8),
    .m_clamped    (m_clamped)
);
